// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the array list RTL.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PAIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define PAIS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/pais_pkg.sv -----
// Shared types and constants for the positional array list unit.
// No dependencies; used by the interfaces, cells, scanner and top level.
package pais_pkg;

  localparam int DEPTH   = 64;
  localparam int WORD_W  = 32;
  localparam int POS_W   = 7;
  localparam int OUT_W   = 7;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // search scanner: match flags are checked one group per cycle
  localparam int GRP     = 8;
  localparam int GRP_LW  = $clog2(GRP);
  localparam int NGRP    = (DEPTH + GRP - 1) / GRP;
  localparam int GRP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int FIDX_W  = GRP_W + GRP_LW;

  localparam logic [OUT_W-1:0] NOT_FOUND = {OUT_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // broadcast from the control to every cell
  typedef struct packed {
    logic              shift_up;
    logic              shift_dn;
    logic              cmp_en;
    logic [CMP_W-1:0]  pos;
    logic [CMP_W-1:0]  cnt;
    logic [WORD_W-1:0] word;
  } pais_ctl_t;

  typedef logic [NGRP-1:0][GRP-1:0] pais_mvec_t;

endpackage

// ----- hw/rtl/pais_if.sv -----
// Valid/ready channels of the array list unit: request and response.
// Depends on pais_pkg for field widths.
interface pais_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          req_type;
  logic [pais_pkg::POS_W-1:0]          position;
  logic signed [pais_pkg::WORD_W-1:0]  word;

  modport source (output valid, req_type, position, word, input ready);
  modport sink   (input valid, req_type, position, word, output ready);
endinterface

interface pais_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic signed [pais_pkg::OUT_W-1:0]  found_index;
  logic [pais_pkg::OUT_W-1:0]         entry_count;

  modport source (output valid, status, found_index, entry_count, input ready);
  modport sink   (input valid, status, found_index, entry_count, output ready);
endinterface

// ----- hw/rtl/pais_cell.sv -----
// One slot of the shifting array: holds an entry and its search match flag.
// Depends on pais_pkg (pais_ctl_t).
module pais_cell (
  input  logic                      clk_i,
  input  pais_pkg::pais_ctl_t       ctl_i,
  input  logic [pais_pkg::CMP_W-1:0]  idx_i,
  input  logic [pais_pkg::WORD_W-1:0] lo_i,
  input  logic [pais_pkg::WORD_W-1:0] hi_i,
  output logic [pais_pkg::WORD_W-1:0] entry_o,
  output logic                      match_o
);
  import pais_pkg::*;

  logic [WORD_W-1:0] entry_q, entry_d;
  logic              match_q, match_d;
  logic              above, at, live;

  assign above = idx_i > ctl_i.pos;
  assign at    = idx_i == ctl_i.pos;
  assign live  = idx_i < ctl_i.cnt;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift_up && above) begin
      entry_d = lo_i;
    end else if (ctl_i.shift_up && at) begin
      entry_d = ctl_i.word;
    end else if (ctl_i.shift_dn && (above || at)) begin
      entry_d = hi_i;
    end
  end

  assign match_d = ctl_i.cmp_en ? (live && (entry_q == ctl_i.word)) : match_q;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ----- hw/rtl/pais_scan.sv -----
// Lowest-set-flag finder: walks the cell match flags one group per cycle.
// Depends on pais_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pais_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  pais_pkg::pais_mvec_t        match_i,
  output logic                        done_o,
  output logic                        hit_o,
  output logic [pais_pkg::FIDX_W-1:0] idx_o
);
  import pais_pkg::*;

  logic             busy_q, busy_d;
  logic [GRP_W-1:0] grp_q, grp_d;
  logic [GRP-1:0]   bits;
  logic [GRP_LW-1:0] low;
  logic             last;

  assign bits  = match_i[grp_q];
  assign hit_o = |bits;
  assign last  = grp_q == GRP_W'(NGRP - 1);

  // lowest set flag in the current group
  always_comb begin
    low = '0;
    for (int j = GRP - 1; j >= 0; j--) begin
      if (bits[j]) low = GRP_LW'(j);
    end
  end

  assign done_o = busy_q && (hit_o || last);
  assign idx_o  = {grp_q, low};

  always_comb begin
    busy_d = busy_q;
    grp_d  = grp_q;
    if (start_i) begin
      busy_d = 1'b1;
      grp_d  = '0;
    end else if (done_o) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      grp_d = grp_q + GRP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      grp_q  <= '0;
    end else begin
      busy_q <= busy_d;
      grp_q  <= grp_d;
    end
  end

  `PAIS_NEVER(a_start_busy, start_i && busy_q, "scan restarted while busy")
  `PAIS_ASSERT(a_hit_range, (done_o && hit_o) |-> (int'(idx_o) < DEPTH), "hit past last cell")

endmodule

// ----- hw/rtl/positional_array_insert_delete_search_unit.sv -----
// Positional array list: insert / delete / linear search over a row of cells.
// Depends on pais_pkg, pais_if, pais_cell, pais_scan and assert_macros.svh.
//
//   channel  dir  payload                              handshake
//   req_i    in   req_type, position, word             valid/ready
//   rsp_o    out  status, found_index, entry_count     valid/ready
//
// Insert and delete: every cell shifts in parallel in the accept cycle. Search
// time is set by the group scanner, which checks 8 match flags per cycle and
// stops at the first group with a hit or at the last group.
// Reset clears the entry count and the handshake state; cell contents are
// only read below the count. A result waits in a holding register while the
// output register is stalled; a new word is taken once that result has moved.
`include "assert_macros.svh"

module positional_array_insert_delete_search_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  pais_req_if.sink    req_i,
  pais_rsp_if.source  rsp_o
);
  import pais_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              acc;
  logic              ins_ok, del_ok, is_search;
  status_e           st;
  logic [CMP_W-1:0]  pos_x, cnt_x;
  pais_ctl_t         ctl;

  logic [WORD_W-1:0] ent [DEPTH];
  logic [DEPTH-1:0]  match_w;
  pais_mvec_t        mvec;

  logic              scan_done, scan_hit;
  logic [FIDX_W-1:0] scan_idx;

  logic [1:0]        res_status_q;
  logic [OUT_W-1:0]  res_found_q, res_count_q;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic [1:0]        out_status_q;
  logic [OUT_W-1:0]  out_found_q, out_count_q;

  assign req_i.ready = state_q == S_IDLE;
  assign acc   = req_i.valid && req_i.ready;
  assign pos_x = CMP_W'(req_i.position);
  assign cnt_x = CMP_W'(count_q);

  always_comb begin
    st        = ST_OK;
    ins_ok    = 1'b0;
    del_ok    = 1'b0;
    is_search = 1'b0;
    case (req_e'(req_i.req_type))
      REQ_INSERT: begin
        if (pos_x > cnt_x) begin
          st = ST_BADPOS;
        end else if (count_q == CNT_W'(DEPTH)) begin
          st = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (count_q == '0) begin
          st = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          st = ST_BADPOS;
        end else begin
          del_ok = 1'b1;
        end
      end
      REQ_SEARCH: is_search = 1'b1;
      default: ;  // unused code: no change
    endcase
  end

  assign ctl.shift_up = acc && ins_ok;
  assign ctl.shift_dn = acc && del_ok;
  assign ctl.cmp_en   = acc && is_search;
  assign ctl.pos      = pos_x;
  assign ctl.cnt      = cnt_x;
  assign ctl.word     = req_i.word;

  always_comb begin
    count_d = count_q;
    if (ctl.shift_up) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctl.shift_dn) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] lo, hi;
    if (i == 0) begin : g_first
      assign lo = '0;
    end else begin : g_lo
      assign lo = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign hi = '0;
    end else begin : g_hi
      assign hi = ent[i+1];
    end
    pais_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .idx_i   (CMP_W'(i)),
      .lo_i    (lo),
      .hi_i    (hi),
      .entry_o (ent[i]),
      .match_o (match_w[i])
    );
  end

  assign mvec = pais_mvec_t'((NGRP * GRP)'(match_w));

  pais_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl.cmp_en),
    .match_i (mvec),
    .done_o  (scan_done),
    .hit_o   (scan_hit),
    .idx_o   (scan_idx)
  );

  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (acc) state_d = is_search ? S_SCAN : S_DONE;
      S_SCAN: if (scan_done) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == S_DONE && out_free) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result holding and output words
  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_status_q <= st;
      res_found_q  <= NOT_FOUND;
      res_count_q  <= OUT_W'(count_d);
    end else if (state_q == S_SCAN && scan_done) begin
      res_found_q  <= scan_hit ? OUT_W'(scan_idx) : NOT_FOUND;
    end
    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_count_q  <= res_count_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.found_index = out_found_q;
  assign rsp_o.entry_count = out_count_q;

  `PAIS_ASSERT(a_count_max, count_q <= CNT_W'(DEPTH), "entry count past capacity")
  `PAIS_ASSERT(a_ins_count, (acc && ins_ok) |=> (count_q == $past(count_q) + CNT_W'(1)), "insert lost count")
  `PAIS_ASSERT(a_scan_state, scan_done |-> (state_q == S_SCAN), "scan finished outside search")
  `PAIS_ASSERT(a_done_moves, (state_q == S_DONE && !out_valid_q) |=> out_valid_q, "result not moved to free output")

endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for the positional array list unit: insert, delete, search.
// Needs pais_pkg, the pais_req_if / pais_rsp_if channels and the unit itself.
// Directed rows come first, then random phases checked by a list predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pais_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         RAND_ITEMS  = 850;
  localparam int         STALL_LIMIT = 2000;
  localparam int         TAIL_CYCLES = 24;
  localparam int         IDLE_PCT    = 20;
  localparam int         CALM_LO     = 350;
  localparam int         CALM_HI     = 500;

  typedef enum int {PH_FILL, PH_MIX, PH_DRAIN, PH_NOISE} phase_e;

  typedef struct {
    logic [1:0]               req_type;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] word;
  } req_word_t;

  typedef struct {
    status_e                 status;
    logic signed [OUT_W-1:0] found_index;
    logic [OUT_W-1:0]        entry_count;
  } list_rsp_t;

  typedef struct {
    req_word_t w;
    bit        pinned;
    list_rsp_t rsp;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  pais_req_if req_if ();
  pais_rsp_if rsp_if ();

  positional_array_insert_delete_search_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // predictor state: the packed list, index 0 first
  logic signed [WORD_W-1:0] held_words[$];
  list_rsp_t                pending_rsp[$];
  stim_row_t                dir_table[$];

  int        errors;
  int        stall_cycles;
  bit        calm;
  bit        cur_pinned;
  list_rsp_t cur_pinned_rsp;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic stim_row_t row(logic [1:0] rq, logic [POS_W-1:0] pos,
                                    logic signed [WORD_W-1:0] wd, bit pin,
                                    status_e st = ST_OK,
                                    logic [OUT_W-1:0] fidx = NOT_FOUND,
                                    logic [OUT_W-1:0] cnt = '0);
    stim_row_t r;
    r.w.req_type = rq;
    r.w.position = pos;
    r.w.word = wd;
    r.pinned = pin;
    r.rsp.status = st;
    r.rsp.found_index = fidx;
    r.rsp.entry_count = cnt;
    return r;
  endfunction

  // applies one request to the list and returns the result word it gives
  function automatic list_rsp_t apply_request(req_word_t w);
    list_rsp_t r;
    int n;
    n = held_words.size();
    r.status = ST_OK;
    r.found_index = NOT_FOUND;
    case (w.req_type)
      REQ_INSERT: begin
        // position is checked before capacity
        if (int'(w.position) > n) r.status = ST_BADPOS;
        else if (n >= DEPTH) r.status = ST_FULL;
        else held_words.insert(int'(w.position), w.word);
      end
      REQ_DELETE: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (int'(w.position) >= n) r.status = ST_BADPOS;
        else held_words.delete(int'(w.position));
      end
      REQ_SEARCH: begin
        for (int i = 0; i < n; i++) begin
          if (held_words[i] == w.word) begin
            r.found_index = OUT_W'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = OUT_W'(held_words.size());
    return r;
  endfunction

  // random request shaped by phase; legal positions mostly, noise otherwise
  function automatic req_word_t next_request(phase_e ph);
    req_word_t w;
    int n;
    int roll;
    int ins_pct;
    int del_pct;
    int noise_pct;
    bit noisy;
    n = held_words.size();
    case (ph)
      PH_FILL:  begin ins_pct = 80; del_pct = 8;  end
      PH_DRAIN: begin ins_pct = 10; del_pct = 75; end
      default:  begin ins_pct = 40; del_pct = 35; end
    endcase
    noise_pct = (ph == PH_NOISE) ? 50 : 8;
    noisy = ($urandom_range(0, 99) < noise_pct);

    roll = $urandom_range(0, 99);
    // small values make duplicates, so lowest-index matches get exercised
    if (roll < 30) w.word = WORD_W'($urandom_range(0, 7));
    else if (roll < 33) w.word = 32'sh7FFF_FFFF;
    else if (roll < 36) w.word = 32'sh8000_0000;
    else w.word = $urandom;
    w.position = POS_W'($urandom_range(0, 127));

    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      w.req_type = REQ_UNUSED;
    end else if (roll < 3 + ins_pct) begin
      w.req_type = REQ_INSERT;
      if (!noisy) begin
        case ($urandom_range(0, 3))
          0:       w.position = '0;
          1:       w.position = POS_W'(n);
          default: w.position = POS_W'($urandom_range(0, n));
        endcase
      end
    end else if (roll < 3 + ins_pct + del_pct) begin
      w.req_type = REQ_DELETE;
      if (!noisy && n > 0) begin
        case ($urandom_range(0, 3))
          0:       w.position = '0;
          1:       w.position = POS_W'(n - 1);
          default: w.position = POS_W'($urandom_range(0, n - 1));
        endcase
      end
    end else begin
      w.req_type = REQ_SEARCH;
      if (!noisy && n > 0 && $urandom_range(0, 99) < 65)
        w.word = held_words[$urandom_range(0, n - 1)];
    end
    return w;
  endfunction

  // drive one word at the falling edge, return after it is taken
  task automatic send_word(input req_word_t w, input bit pin, input list_rsp_t pin_rsp);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cur_pinned = pin;
    cur_pinned_rsp = pin_rsp;
    req_if.valid <= 1'b1;
    req_if.req_type <= w.req_type;
    req_if.position <= w.position;
    req_if.word <= w.word;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // request monitor: run the predictor on every accepted word
  always @(posedge clk_i) begin : req_mon
    list_rsp_t r;
    if (rst_ni && req_if.valid && req_if.ready) begin
      r = apply_request('{req_if.req_type, req_if.position, req_if.word});
      pending_rsp.push_back(cur_pinned ? cur_pinned_rsp : r);
    end
  end

  // response checker
  always @(posedge clk_i) begin : rsp_check
    list_rsp_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result: status %0d found %0d count %0d", $time,
                   rsp_if.status, rsp_if.found_index, rsp_if.entry_count);
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_if.status !== e.status || rsp_if.found_index !== e.found_index ||
            rsp_if.entry_count !== e.entry_count) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result mismatch: exp status %0d found %0d count %0d, got %0d %0d %0d",
                     $time, e.status, e.found_index, e.entry_count,
                     rsp_if.status, rsp_if.found_index, rsp_if.entry_count);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= rst_ni && (calm || ($urandom_range(0, 99) >= IDLE_PCT));
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stim
    req_word_t w;
    list_rsp_t none;
    phase_e    ph;
    int        rand_sent;
    int        phase_cnt;
    int        phase_len;

    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = '0;
    req_if.position = '0;
    req_if.word = '0;
    calm = 1'b0;
    cur_pinned = 1'b0;
    none.status = ST_OK;
    none.found_index = NOT_FOUND;
    none.entry_count = '0;
    cur_pinned_rsp = none;

    // pinned rows carry a fixed expected result in place of the predictor's
    dir_table = '{
      row(REQ_DELETE, 7'd0,   32'sd0,           1'b1, ST_EMPTY,  NOT_FOUND, 7'd0),
      row(REQ_DELETE, 7'd127, 32'shFFFF_FFFF,   1'b1, ST_EMPTY,  NOT_FOUND, 7'd0),
      row(REQ_SEARCH, 7'd0,   32'sd0,           1'b1, ST_OK,     NOT_FOUND, 7'd0),
      row(REQ_UNUSED, 7'd127, 32'shFFFF_FFFF,   1'b1, ST_OK,     NOT_FOUND, 7'd0),
      row(REQ_INSERT, 7'd1,   32'sd5,           1'b1, ST_BADPOS, NOT_FOUND, 7'd0),
      row(REQ_INSERT, 7'd127, 32'sd5,           1'b1, ST_BADPOS, NOT_FOUND, 7'd0),
      row(REQ_INSERT, 7'd0,   32'sh7FFF_FFFF,   1'b1, ST_OK,     NOT_FOUND, 7'd1),
      row(REQ_INSERT, 7'd1,   32'sh8000_0000,   1'b1, ST_OK,     NOT_FOUND, 7'd2),
      row(REQ_INSERT, 7'd0,   32'sd0,           1'b1, ST_OK,     NOT_FOUND, 7'd3),
      row(REQ_SEARCH, 7'd127, 32'sh8000_0000,   1'b0),
      row(REQ_SEARCH, 7'd0,   32'sh7FFF_FFFF,   1'b0),
      row(REQ_SEARCH, 7'd0,   32'shFFFF_FFFF,   1'b0),
      row(REQ_INSERT, 7'd2,   32'sh7FFF_FFFF,   1'b0),
      row(REQ_SEARCH, 7'd0,   32'sh7FFF_FFFF,   1'b0),
      row(REQ_INSERT, 7'd4,   32'shFFFF_FFFF,   1'b0),
      row(REQ_INSERT, 7'd6,   32'sd0,           1'b1, ST_BADPOS, NOT_FOUND, 7'd5),
      row(REQ_DELETE, 7'd5,   32'sd0,           1'b1, ST_BADPOS, NOT_FOUND, 7'd5),
      row(REQ_DELETE, 7'd64,  32'sd0,           1'b0),
      row(REQ_DELETE, 7'd3,   32'sd0,           1'b0),
      row(REQ_UNUSED, 7'd3,   32'sd5,           1'b0),
      row(REQ_DELETE, 7'd0,   32'sd0,           1'b0),
      row(REQ_SEARCH, 7'd0,   32'sd0,           1'b0)
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_table[i]) send_word(dir_table[i].w, dir_table[i].pinned, dir_table[i].rsp);

    // random phases: fill to capacity, mixed traffic, drain past empty, noise
    rand_sent = 0;
    phase_cnt = 0;
    while (rand_sent < RAND_ITEMS) begin
      ph = phase_e'(phase_cnt % 4);
      phase_len = $urandom_range(80, 120);
      for (int k = 0; k < phase_len && rand_sent < RAND_ITEMS; k++) begin
        calm = (rand_sent >= CALM_LO && rand_sent < CALM_HI);
        w = next_request(ph);
        send_word(w, 1'b0, none);
        if (w.req_type != REQ_UNUSED) rand_sent++;
      end
      phase_cnt++;
    end
    calm = 1'b0;
    req_if.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
